FILE: sv/ftct_pkg.sv
// ----------------------------------------------------------------------------
// ftct_pkg
// Shared constants, register codes and sequencer states of the fractional
// tick catch-up timer.
// ----------------------------------------------------------------------------
package ftct_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned STEP_W        = 24;
  localparam int unsigned TIME_W        = 32;
  localparam int unsigned ADDED_W       = 9;
  localparam int unsigned PADDR_W       = 4;
  localparam int unsigned DATA_W        = 32;

  localparam logic [STEP_W-1:0]  STEP_RESET    = 24'd1089536;
  localparam logic [ADDED_W-1:0] CATCHUP_LIMIT = 9'd257;
  localparam logic [TIME_W-1:0]  GAP_LIMIT     = 32'd256;
  localparam logic [TIME_W-1:0]  BEHIND_LIMIT  = 32'hFFFF_FF00;

  // x / 1000 == (x * DIV_MAGIC) >> DIV_SHIFT for every 32-bit x
  localparam int unsigned         MAGIC_W   = 29;
  localparam logic [MAGIC_W-1:0]  DIV_MAGIC = 29'd274877907;
  localparam int unsigned         DIV_SHIFT = 38;
  localparam int unsigned         QUOT_W    = 23;

  typedef enum logic [1:0] {
    REG_STEP         = 2'd0,
    REG_SECONDS_BASE = 2'd1,
    REG_MILLI_BASE   = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_STEP,
    ST_CHECK,
    ST_DELTA,
    ST_MUL,
    ST_DONE
  } state_t;

endpackage

FILE: sv/ftct_sample_if.sv
// ----------------------------------------------------------------------------
// ftct_sample_if
// Input channel: one clock sample and its action per transfer.
// ----------------------------------------------------------------------------
interface ftct_sample_if;
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [ftct_pkg::TIME_W-1:0]  ms_time;

  modport source (output valid, output action, output ms_time, input ready);
  modport sink   (input valid, input action, input ms_time, output ready);
endinterface

FILE: sv/ftct_result_if.sv
// ----------------------------------------------------------------------------
// ftct_result_if
// Output channel: tick and calendar result of one sample per transfer.
// ----------------------------------------------------------------------------
interface ftct_result_if;
  logic                          valid;
  logic                          ready;
  logic [ftct_pkg::ADDED_W-1:0]  ticks_added;
  logic [ftct_pkg::TIME_W-1:0]   tick_total;
  logic                          advanced;
  logic                          interrupted;
  logic                          set_back;
  logic [ftct_pkg::TIME_W-1:0]   date_seconds;
  logic                          date_changed;

  modport source (output valid, output ticks_added, output tick_total, output advanced,
                  output interrupted, output set_back, output date_seconds,
                  output date_changed, input ready);
  modport sink   (input valid, input ticks_added, input tick_total, input advanced,
                  input interrupted, input set_back, input date_seconds,
                  input date_changed, output ready);
endinterface

FILE: sv/fractional_tick_catchup_timer.sv
// ----------------------------------------------------------------------------
// fractional_tick_catchup_timer
// Emulated tick generator driven by samples of a free-running ms clock.
// ----------------------------------------------------------------------------
// Paths: a repeated sample or a small step back runs EVAL, DELTA, MUL, DONE;
//   initialize, resync or a large gap also runs STEP; a catch-up of n ticks
//   (n up to 257) loops STEP and CHECK, one shared deadline adder step per tick.
// Throughput: one sample at a time; next transfer once the result is registered.
// Reset: all timing state and tick count clear, registers take reset values.
module fractional_tick_catchup_timer #(
  parameter int unsigned FRAC_BITS = ftct_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  ftct_sample_if.sink                   sample,
  ftct_result_if.source                 result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ftct_pkg::PADDR_W-1:0]  paddr,
  input  logic [ftct_pkg::DATA_W-1:0]   pwdata,
  output logic [ftct_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  localparam int unsigned TW = ftct_pkg::TIME_W;

  ftct_pkg::state_t state, state_next;

  logic [ftct_pkg::STEP_W-1:0]  step_fixed;
  logic [TW-1:0]                seconds_base;
  logic [TW-1:0]                milli_base;

  logic [TW-1:0]                last_sample;
  logic [TW-1:0]                deadline_whole;
  logic [FRAC_BITS-1:0]         deadline_fraction;
  logic [TW-1:0]                tick_count;
  logic [TW-1:0]                current_seconds;

  logic                         action_r;
  logic [TW-1:0]                sample_r;
  logic                         catchup;
  logic [ftct_pkg::ADDED_W-1:0] added;
  logic                         interrupted_r;
  logic                         set_back_r;
  logic [TW-1:0]                delta;

  logic                         res_valid;
  logic [ftct_pkg::ADDED_W-1:0] res_ticks_added;
  logic [TW-1:0]                res_tick_total;
  logic                         res_advanced;
  logic                         res_interrupted;
  logic                         res_set_back;
  logic [TW-1:0]                res_date_seconds;
  logic                         res_date_changed;

  logic [TW-1:0]                sub_a;
  logic [TW-1:0]                sub_b;
  logic [TW-1:0]                diff;
  logic [TW-1:0]                whole_next;
  logic [FRAC_BITS-1:0]         frac_next;
  logic [ftct_pkg::QUOT_W-1:0]  quotient;
  logic [TW-1:0]                secs;
  logic                         accept;
  logic                         out_free;
  logic                         cfg_write;
  ftct_pkg::reg_idx_t           reg_idx;

  // Shared subtractor: deadline difference or offset from the ms base
  always_comb begin
    if (state == ftct_pkg::ST_DELTA) begin
      sub_a = last_sample;
      sub_b = milli_base;
    end else begin
      sub_a = sample_r;
      sub_b = deadline_whole;
    end
  end

  assign diff = sub_a - sub_b;

  ftct_deadline_unit #(
    .FRAC_BITS (FRAC_BITS)
  ) u_deadline (
    .whole      (deadline_whole),
    .frac       (deadline_fraction),
    .step       (step_fixed),
    .whole_next (whole_next),
    .frac_next  (frac_next)
  );

  ftct_div1000 u_div (
    .clk      (clk),
    .dividend (delta),
    .quotient (quotient)
  );

  assign secs     = TW'(quotient) + seconds_base;
  assign accept   = sample.valid && sample.ready;
  assign out_free = !res_valid || result.ready;

  // Configuration port
  assign pready    = 1'b1;
  assign reg_idx   = ftct_pkg::reg_idx_t'(paddr[ftct_pkg::PADDR_W-1:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_idx)
      ftct_pkg::REG_STEP:         prdata = ftct_pkg::DATA_W'(step_fixed);
      ftct_pkg::REG_SECONDS_BASE: prdata = seconds_base;
      ftct_pkg::REG_MILLI_BASE:   prdata = milli_base;
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_fixed   <= ftct_pkg::STEP_RESET;
      seconds_base <= '0;
      milli_base   <= '0;
    end else if (cfg_write) begin
      case (reg_idx)
        ftct_pkg::REG_STEP:         step_fixed   <= pwdata[ftct_pkg::STEP_W-1:0];
        ftct_pkg::REG_SECONDS_BASE: seconds_base <= pwdata;
        ftct_pkg::REG_MILLI_BASE:   milli_base   <= pwdata;
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ftct_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    sample.ready = 1'b0;
    case (state)
      ftct_pkg::ST_IDLE: begin
        sample.ready = 1'b1;
        if (sample.valid) begin
          state_next = ftct_pkg::ST_EVAL;
        end
      end
      ftct_pkg::ST_EVAL: begin
        if (action_r) begin
          state_next = ftct_pkg::ST_STEP;
        end else if (sample_r == last_sample) begin
          state_next = ftct_pkg::ST_DELTA;
        end else if (!diff[TW-1] || diff < ftct_pkg::BEHIND_LIMIT) begin
          state_next = ftct_pkg::ST_STEP;
        end else begin
          state_next = ftct_pkg::ST_DELTA;
        end
      end
      ftct_pkg::ST_STEP: begin
        state_next = catchup ? ftct_pkg::ST_CHECK : ftct_pkg::ST_DELTA;
      end
      ftct_pkg::ST_CHECK: begin
        if (!diff[TW-1] && added < ftct_pkg::CATCHUP_LIMIT) begin
          state_next = ftct_pkg::ST_STEP;
        end else begin
          state_next = ftct_pkg::ST_DELTA;
        end
      end
      ftct_pkg::ST_DELTA: state_next = ftct_pkg::ST_MUL;
      ftct_pkg::ST_MUL:   state_next = ftct_pkg::ST_DONE;
      ftct_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = ftct_pkg::ST_IDLE;
        end
      end
      default: state_next = ftct_pkg::ST_IDLE;
    endcase
  end

  // Timing state
  always_ff @(posedge clk) begin
    if (rst) begin
      last_sample       <= '0;
      deadline_whole    <= '0;
      deadline_fraction <= '0;
      tick_count        <= '0;
      current_seconds   <= '0;
      catchup           <= 1'b0;
    end else begin
      case (state)
        ftct_pkg::ST_EVAL: begin
          if (action_r) begin
            last_sample       <= sample_r;
            deadline_whole    <= sample_r;
            deadline_fraction <= '0;
          end else if (sample_r != last_sample) begin
            last_sample <= sample_r;
            if (!diff[TW-1]) begin
              if (diff > ftct_pkg::GAP_LIMIT) begin
                tick_count        <= tick_count + 1'b1;
                deadline_whole    <= sample_r;
                deadline_fraction <= '0;
              end else begin
                catchup <= 1'b1;
              end
            end else if (diff < ftct_pkg::BEHIND_LIMIT) begin
              deadline_whole    <= sample_r;
              deadline_fraction <= '0;
            end
          end
        end
        ftct_pkg::ST_STEP: begin
          deadline_whole    <= whole_next;
          deadline_fraction <= frac_next;
          if (catchup) begin
            tick_count <= tick_count + 1'b1;
          end
        end
        ftct_pkg::ST_DONE: begin
          if (out_free) begin
            current_seconds <= secs;
          end
        end
        default: ;
      endcase
      if (accept) begin
        catchup <= 1'b0;
      end
    end
  end

  // Per-item working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      action_r      <= sample.action;
      sample_r      <= sample.ms_time;
      added         <= '0;
      interrupted_r <= 1'b0;
      set_back_r    <= 1'b0;
    end else begin
      case (state)
        ftct_pkg::ST_EVAL: begin
          if (!action_r && sample_r != last_sample) begin
            if (!diff[TW-1]) begin
              if (diff > ftct_pkg::GAP_LIMIT) begin
                added         <= ftct_pkg::ADDED_W'(1);
                interrupted_r <= 1'b1;
              end
            end else if (diff < ftct_pkg::BEHIND_LIMIT) begin
              set_back_r <= 1'b1;
            end
          end
        end
        ftct_pkg::ST_STEP: begin
          if (catchup) begin
            added <= added + 1'b1;
          end
        end
        ftct_pkg::ST_DELTA: delta <= diff;
        default: ;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == ftct_pkg::ST_DONE && out_free) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ftct_pkg::ST_DONE && out_free) begin
      res_ticks_added  <= added;
      res_tick_total   <= tick_count;
      res_advanced     <= (added != '0);
      res_interrupted  <= interrupted_r;
      res_set_back     <= set_back_r;
      res_date_seconds <= secs;
      res_date_changed <= (secs != current_seconds);
    end
  end

  assign result.valid        = res_valid;
  assign result.ticks_added  = res_ticks_added;
  assign result.tick_total   = res_tick_total;
  assign result.advanced     = res_advanced;
  assign result.interrupted  = res_interrupted;
  assign result.set_back     = res_set_back;
  assign result.date_seconds = res_date_seconds;
  assign result.date_changed = res_date_changed;

  // Checks
  a_step_counts_tick: assert property (@(posedge clk) disable iff (rst)
    (state == ftct_pkg::ST_STEP && catchup) |=> tick_count == $past(tick_count) + 1'b1)
    else $error("catch-up step did not add exactly one tick");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    accept |=> !sample.ready)
    else $error("sample taken while previous one still in work");

  a_catchup_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ftct_pkg::ST_CHECK) |-> added <= ftct_pkg::CATCHUP_LIMIT)
    else $error("catch-up loop ran past its limit");

  a_interrupt_one_tick: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.interrupted) |->
      (result.ticks_added == ftct_pkg::ADDED_W'(1) && !result.set_back))
    else $error("resync result inconsistent");

endmodule

FILE: sv/ftct_deadline_unit.sv
// ----------------------------------------------------------------------------
// ftct_deadline_unit
// Advance a fixed-point deadline by one step period.
// ----------------------------------------------------------------------------
module ftct_deadline_unit #(
  parameter int unsigned FRAC_BITS = ftct_pkg::FRAC_BITS_DEF
) (
  input  logic [ftct_pkg::TIME_W-1:0] whole,
  input  logic [FRAC_BITS-1:0]        frac,
  input  logic [ftct_pkg::STEP_W-1:0] step,
  output logic [ftct_pkg::TIME_W-1:0] whole_next,
  output logic [FRAC_BITS-1:0]        frac_next
);
  localparam int unsigned SUM_W =
    ((FRAC_BITS > ftct_pkg::STEP_W) ? FRAC_BITS : ftct_pkg::STEP_W) + 1;
  localparam int unsigned CARRY_W = SUM_W - FRAC_BITS;

  logic [SUM_W-1:0]   sum;
  logic [CARRY_W-1:0] carry;

  assign sum        = SUM_W'(frac) + SUM_W'(step);
  assign carry      = sum[SUM_W-1:FRAC_BITS];
  assign whole_next = whole + ftct_pkg::TIME_W'(carry);
  assign frac_next  = sum[FRAC_BITS-1:0];
endmodule

FILE: sv/ftct_div1000.sv
// ----------------------------------------------------------------------------
// ftct_div1000
// Divide a 32-bit value by 1000 through a registered reciprocal multiply.
// ----------------------------------------------------------------------------
module ftct_div1000 (
  input  logic                         clk,
  input  logic [ftct_pkg::TIME_W-1:0]  dividend,
  output logic [ftct_pkg::QUOT_W-1:0]  quotient
);
  localparam int unsigned PROD_W = ftct_pkg::TIME_W + ftct_pkg::MAGIC_W;

  logic [PROD_W-1:0] product;

  always_ff @(posedge clk) begin
    product <= {{ftct_pkg::MAGIC_W{1'b0}}, dividend} *
               {{ftct_pkg::TIME_W{1'b0}}, ftct_pkg::DIV_MAGIC};
  end

  assign quotient = product[ftct_pkg::DIV_SHIFT +: ftct_pkg::QUOT_W];
endmodule
